// ===== hw/rtl/bmfa_pkg.sv =====
// ----------------------------------------------------------------------------
// bmfa_pkg: shared types and constants for the bitmap first-free allocator
// Payload structs, status codes, register indexes and the word priority
// encoder used by the scan.
// ----------------------------------------------------------------------------
package bmfa_pkg;

	localparam int MAP_BITS_DEF = 1024;
	localparam int WORD_BITS    = 64;
	localparam int BIT_W        = 6;
	localparam int CNT_W        = 11;
	localparam int COUNT_RESET  = 1024;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_FULL  = 2'd1;
	localparam logic [1:0] ST_RANGE = 2'd2;

	localparam logic REG_INODE_COUNT = 1'b0;
	localparam logic REG_BLOCK_COUNT = 1'b1;

	localparam logic KIND_ALLOC = 1'b0;
	localparam logic KIND_FREE  = 1'b1;

	typedef struct packed {
		logic             kind;
		logic             map_select;
		logic [CNT_W-1:0] number;
	} in_t;

	typedef struct packed {
		logic [CNT_W-1:0] granted;
		logic [1:0]       status;
	} out_t;

	// index of the lowest set bit, 0 when none
	function automatic logic [BIT_W-1:0] lowest_set(input logic [WORD_BITS-1:0] v);
		logic [BIT_W-1:0] idx;
		idx = '0;
		for (int i = WORD_BITS - 1; i >= 0; i--) begin
			if (v[i]) begin
				idx = BIT_W'(i);
			end
		end
		return idx;
	endfunction

endpackage

// ===== hw/rtl/bmfa_map_mem.sv =====
// ----------------------------------------------------------------------------
// bmfa_map_mem: word store for both usage maps
// One write and one registered read port. A per-row valid bit, cleared by
// reset, makes rows never written since reset read as all zero.
// ----------------------------------------------------------------------------
module bmfa_map_mem #(
	parameter int ROWS = 32,
	parameter int AW   = 5
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          wr_en,
	input  logic [AW-1:0]                 wr_addr,
	input  logic [bmfa_pkg::WORD_BITS-1:0] wr_data,
	input  logic [AW-1:0]                 rd_addr,
	output logic [bmfa_pkg::WORD_BITS-1:0] rd_data
);
	import bmfa_pkg::*;

	logic [WORD_BITS-1:0] mem_q [ROWS];
	logic [ROWS-1:0]      row_valid_q;
	logic [WORD_BITS-1:0] rd_data_q;
	logic                 rd_valid_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data_q <= mem_q[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_valid_q <= '0;
			rd_valid_q  <= 1'b0;
		end else begin
			if (wr_en) begin
				row_valid_q[wr_addr] <= 1'b1;
			end
			rd_valid_q <= row_valid_q[rd_addr];
		end
	end

	assign rd_data = rd_valid_q ? rd_data_q : '0;

endmodule

// ===== hw/rtl/bitmap_first_free_allocator.sv =====
// ----------------------------------------------------------------------------
// bitmap_first_free_allocator: first-fit allocator over inode and block maps
// Two usage bitmaps in one word store; allocate scans for the first clear
// bit below the configured count, free clears a bit with a range check.
// ----------------------------------------------------------------------------
// One request is handled at a time; in_ready is high only while the block is
// idle. The maps live as 64-bit words in a single memory with one read and one
// write port, and a single 64-bit priority encoder scans one word per cycle.
// An allocate reads words in order up to the first word with a free bit, at
// most ceil(count/64) words (16 for a count of 1024). A free reads its word,
// clears the bit in CLEAR and then answers from RESP; a free out of range or an
// allocate on a count of zero goes straight to RESP. Maps are clear right
// after reset, with no sweep. A finished result waits in the output register,
// and the next request is taken while it waits; if that request finishes
// before the waiting result is taken, the block holds until it is.
// ----------------------------------------------------------------------------
module bitmap_first_free_allocator #(
	parameter int MAP_BITS = bmfa_pkg::MAP_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  bmfa_pkg::in_t                in_data,
	output logic                         out_valid,
	input  logic                         out_ready,
	output bmfa_pkg::out_t               out_data,
	input  logic                         cfg_we,
	input  logic                         cfg_index,
	input  logic [bmfa_pkg::CNT_W-1:0]   cfg_data
);
	import bmfa_pkg::*;

	localparam int WORDS   = (MAP_BITS + WORD_BITS - 1) / WORD_BITS;
	localparam int WI_W    = (WORDS > 1) ? $clog2(WORDS) : 1;
	localparam int ROWS    = 2 * WORDS;
	localparam int AW      = WI_W + 1;
	localparam int POS_W   = ((WI_W + BIT_W) > CNT_W ? (WI_W + BIT_W) : CNT_W) + 1;
	localparam int CNT_RST = (MAP_BITS < COUNT_RESET) ? MAP_BITS : COUNT_RESET;

	typedef enum logic [1:0] {IDLE, SCAN, CLEAR, RESP} state_t;

	state_t               state_q;
	logic                 sel_q;
	logic [WI_W-1:0]      word_q;
	logic [BIT_W-1:0]     bit_q;
	out_t                 res_q;
	out_t                 out_q;
	logic                 out_valid_q;
	logic [CNT_W-1:0]     inode_count_q;
	logic [CNT_W-1:0]     block_count_q;

	logic [CNT_W-1:0]     lim_in;
	logic [CNT_W-1:0]     limit;
	logic [CNT_W-1:0]     num_m1;
	logic                 range_bad;
	logic [WI_W-1:0]      free_word;
	logic [POS_W-1:0]     base;
	logic                 full_word;
	logic                 last_word;
	logic [BIT_W-1:0]     rem;
	logic [WORD_BITS-1:0] lim_mask;
	logic [WORD_BITS-1:0] free_bits;
	logic                 found;
	logic [BIT_W-1:0]     hit;
	logic [BIT_W-1:0]     bit_pos;
	logic [WORD_BITS-1:0] bit_onehot;
	logic [WI_W-1:0]      next_word;
	logic                 wr_en;
	logic [AW-1:0]        wr_addr;
	logic [WORD_BITS-1:0] wr_data;
	logic [AW-1:0]        rd_addr;
	logic [WORD_BITS-1:0] rd_word;
	logic                 in_xfer;

	function automatic logic [CNT_W-1:0] clamp_count(input logic [CNT_W-1:0] v);
		return (int'(v) > MAP_BITS) ? CNT_W'(MAP_BITS) : v;
	endfunction

	assign in_ready  = (state_q == IDLE);
	assign in_xfer   = in_valid && in_ready;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// request decode
	assign lim_in    = in_data.map_select ? block_count_q : inode_count_q;
	assign limit     = sel_q ? block_count_q : inode_count_q;
	assign num_m1    = in_data.number - CNT_W'(1);
	assign range_bad = (in_data.number == '0) || (in_data.number > lim_in);
	assign free_word = WI_W'(num_m1 >> BIT_W);

	// scan of the current word
	assign base      = POS_W'({word_q, {BIT_W{1'b0}}});
	assign full_word = (base + POS_W'(WORD_BITS)) <= POS_W'(limit);
	assign last_word = (base + POS_W'(WORD_BITS)) >= POS_W'(limit);
	assign rem       = BIT_W'(POS_W'(limit) - base);
	assign lim_mask  = full_word ? '1 : ~({WORD_BITS{1'b1}} << rem);
	assign free_bits = ~rd_word & lim_mask;
	assign found     = |free_bits;
	assign hit       = lowest_set(free_bits);
	assign next_word = last_word ? word_q : word_q + WI_W'(1);

	assign bit_pos    = (state_q == SCAN) ? hit : bit_q;
	assign bit_onehot = {{(WORD_BITS-1){1'b0}}, 1'b1} << bit_pos;

	assign wr_en   = ((state_q == SCAN) && found) || (state_q == CLEAR);
	assign wr_addr = {sel_q, word_q};
	assign wr_data = (state_q == SCAN) ? (rd_word | bit_onehot) : (rd_word & ~bit_onehot);

	always_comb begin
		case (state_q)
			IDLE: begin
				if (in_data.kind == KIND_FREE) begin
					rd_addr = {in_data.map_select, free_word};
				end else begin
					rd_addr = {in_data.map_select, {WI_W{1'b0}}};
				end
			end
			SCAN:    rd_addr = {sel_q, next_word};
			default: rd_addr = {sel_q, word_q};
		endcase
	end

	bmfa_map_mem #(
		.ROWS(ROWS),
		.AW  (AW)
	) u_map_mem (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_addr(rd_addr),
		.rd_data(rd_word)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inode_count_q <= CNT_W'(CNT_RST);
			block_count_q <= CNT_W'(CNT_RST);
		end else if (cfg_we) begin
			case (cfg_index)
				REG_INODE_COUNT: inode_count_q <= clamp_count(cfg_data);
				REG_BLOCK_COUNT: block_count_q <= clamp_count(cfg_data);
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= IDLE;
			sel_q       <= 1'b0;
			word_q      <= '0;
			bit_q       <= '0;
			res_q       <= '0;
			out_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready && (state_q != RESP)) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				IDLE: begin
					if (in_xfer) begin
						sel_q         <= in_data.map_select;
						res_q.granted <= '0;
						if (in_data.kind == KIND_FREE) begin
							word_q <= free_word;
							bit_q  <= num_m1[BIT_W-1:0];
							if (range_bad) begin
								res_q.status <= ST_RANGE;
								state_q      <= RESP;
							end else begin
								res_q.status <= ST_OK;
								state_q      <= CLEAR;
							end
						end else begin
							word_q <= '0;
							if (lim_in == '0) begin
								res_q.status <= ST_FULL;
								state_q      <= RESP;
							end else begin
								state_q <= SCAN;
							end
						end
					end
				end
				SCAN: begin
					if (found) begin
						res_q.granted <= CNT_W'(base + POS_W'(hit) + POS_W'(1));
						res_q.status  <= ST_OK;
						state_q       <= RESP;
					end else if (last_word) begin
						res_q.granted <= '0;
						res_q.status  <= ST_FULL;
						state_q       <= RESP;
					end else begin
						word_q <= next_word;
					end
				end
				CLEAR: begin
					state_q <= RESP;
				end
				RESP: begin
					if (!out_valid_q || out_ready) begin
						out_q       <= res_q;
						out_valid_q <= 1'b1;
						state_q     <= IDLE;
					end
				end
				default: begin
					state_q <= IDLE;
				end
			endcase
		end
	end

	// one request in flight at a time
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer |=> !in_ready)
		else $error("request taken while busy");

	// a failed request never grants a number
	a_fail_no_grant: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_data.status != ST_OK) |-> (out_data.granted == '0))
		else $error("grant with failure status");

	// the map is written only by a scan hit or a free
	a_write_state: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> (state_q == SCAN || state_q == CLEAR))
		else $error("map write outside scan or clear");

	// status is always a defined code
	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_data.status == ST_OK || out_data.status == ST_FULL ||
			out_data.status == ST_RANGE))
		else $error("undefined status code");

endmodule
